// ===== rtl/ctlt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctlt_pkg: shared types and constants for the command line tokenizer
// Result kinds, quote states, character codes and the result record.
// ----------------------------------------------------------------------------
package ctlt_pkg;

   localparam int MAX_WORDS_DEF = 16;
   localparam int RSP_DEPTH     = 4;

   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_PIPE   = 8'h7C;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   typedef enum logic [2:0] {
      KIND_WORD_BYTE  = 3'd0,
      KIND_WORD_END   = 3'd1,
      KIND_PIPE_START = 3'd2,
      KIND_PIPE_BYTE  = 3'd3,
      KIND_LINE_END   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_SINGLE = 2'd1,
      QUOTE_DOUBLE = 2'd2
   } quote_type;

   typedef enum logic {
      ACTION_CHAR = 1'b0,
      ACTION_EOL  = 1'b1
   } action_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic [4:0] word_index;
      logic       has_pipeline;
      logic       last_result;
   } rsp_item_type;

endpackage

// ===== rtl/ctlt_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// ctlt_rsp_queue: result queue
// Small register queue that takes up to two results per cycle and hands out
// one per cycle; ready toward the parser means room for two.
// ----------------------------------------------------------------------------
module ctlt_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_n,
   input  ctlt_pkg::rsp_item_type push_item0,
   input  ctlt_pkg::rsp_item_type push_item1,
   output logic                  space_ok,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ctlt_pkg::rsp_item_type out_item
);
   import ctlt_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_item_type            slot_ff [RSP_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PTR_W-1:0]        wr_ptr_nxt;
   logic                    pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign space_ok  = (count_ff <= CNT_W'(RSP_DEPTH - 2));
   assign pop       = out_valid && out_ready;
   assign wr_ptr_nxt = PTR_W'(wr_ptr_ff + 1'b1);

   always_comb begin
      wr_ptr_in = PTR_W'(wr_ptr_ff + PTR_W'(push_n));
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = CNT_W'(count_ff + CNT_W'(push_n) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_item0;
      end
      if (push_n == 2'd2) begin
         slot_ff[wr_ptr_nxt] <= push_item1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> (count_ff <= CNT_W'(RSP_DEPTH - 2)))
      else $error("result queue written without room");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("result queue pointers disagree with empty count");

endmodule

// ===== rtl/command_line_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit: shell style word splitter
// Splits a command line into words, honoring quotes, escapes and the start
// of pipeline text, one byte per transaction.
//
// Usage:
//   req channel takes one byte (tdata) or an end of line marker (tuser = 1).
//   rsp channel gives results: word bytes, word ends, pipeline bytes and a
//   line end record with the word count and pipeline flag; tlast marks the
//   last result of an input transaction.
//   A byte produces zero or one result, an end of line one or two.
//   A result is registered in the result queue before it appears on rsp.
//   One input is taken per cycle while the receiver keeps up; each end of
//   line that closes a word yields two results. The four entry result
//   queue sets this: req_tready is high while it has room for two results.
//   When the receiver stalls, results wait in the queue and req_tready
//   drops once fewer than two slots are free; nothing is lost.
//   Reset clears the parse state (no quote, between words, word count zero)
//   and empties the result queue.
// ----------------------------------------------------------------------------
module command_line_tokenizer_unit #(
   parameter int MAX_WORDS = ctlt_pkg::MAX_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [12:8] word_index,
                                    // [13] has_pipeline, [15:14] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // last_result
);
   import ctlt_pkg::*;

   localparam int CNT_W = $clog2(MAX_WORDS + 2);

   quote_type        quote_ff, quote_in;
   logic             escape_ff, escape_in;
   logic             between_ff, between_in;
   logic             pipe_ff, pipe_in;
   logic             nonempty_ff, nonempty_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             accept;
   logic             is_ws;
   logic             is_quote;
   quote_type        char_quote;
   logic [1:0]       push_n;
   rsp_item_type     item0, item1, out_item;
   logic             space_ok;
   logic [CNT_W-1:0] count_plus;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = space_ok;
   assign count_plus = CNT_W'(count_ff + 1'b1);

   always_comb begin
      is_ws      = (req_tdata == CHAR_SPACE) ||
                   ((req_tdata >= CHAR_TAB) && (req_tdata <= CHAR_CR));
      is_quote   = (req_tdata == CHAR_DQUOTE) || (req_tdata == CHAR_SQUOTE);
      char_quote = (req_tdata == CHAR_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
   end

   always_comb begin
      quote_in    = quote_ff;
      escape_in   = escape_ff;
      between_in  = between_ff;
      pipe_in     = pipe_ff;
      nonempty_in = nonempty_ff;
      count_in    = count_ff;
      push_n      = 2'd0;
      item0       = '{kind: KIND_WORD_BYTE, out_byte: req_tdata,
                      word_index: 5'(count_ff), has_pipeline: 1'b0,
                      last_result: 1'b1};
      item1       = '{kind: KIND_LINE_END, out_byte: 8'd0,
                      word_index: 5'(count_ff), has_pipeline: pipe_ff,
                      last_result: 1'b1};

      if (accept) begin
         if (req_tuser == ACTION_EOL) begin
            // close a pending word, then report totals and clear state
            if (nonempty_ff && !pipe_ff) begin
               item0 = '{kind: KIND_WORD_END, out_byte: 8'd0,
                         word_index: 5'(count_ff), has_pipeline: 1'b0,
                         last_result: 1'b0};
               item1.word_index = 5'(count_plus);
               push_n = 2'd2;
            end else begin
               item0  = item1;
               push_n = 2'd1;
            end
            quote_in    = QUOTE_NONE;
            escape_in   = 1'b0;
            between_in  = 1'b1;
            pipe_in     = 1'b0;
            nonempty_in = 1'b0;
            count_in    = '0;
         end else if (count_ff < CNT_W'(MAX_WORDS)) begin
            if (pipe_ff) begin
               item0.kind  = KIND_PIPE_BYTE;
               push_n      = 2'd1;
            end else if (escape_ff) begin
               escape_in   = 1'b0;
               push_n      = 2'd1;
            end else if (is_ws && quote_ff == QUOTE_NONE) begin
               if (!between_ff) begin
                  item0.kind     = KIND_WORD_END;
                  item0.out_byte = 8'd0;
                  push_n         = 2'd1;
                  count_in       = count_plus;
                  nonempty_in    = 1'b0;
                  between_in     = 1'b1;
               end
            end else if (is_quote &&
                         (quote_ff == QUOTE_NONE || quote_ff == char_quote)) begin
               // toggle quoting, drop the quote byte
               quote_in   = (quote_ff == QUOTE_NONE) ? char_quote : QUOTE_NONE;
               between_in = 1'b0;
            end else if (req_tdata == CHAR_BSLASH) begin
               escape_in  = 1'b1;
               between_in = 1'b0;
            end else begin
               if (((req_tdata == CHAR_GT) || (req_tdata == CHAR_PIPE)) &&
                   quote_ff == QUOTE_NONE) begin
                  pipe_in    = 1'b1;
                  item0.kind = KIND_PIPE_START;
               end
               push_n = 2'd1;
            end
            if (push_n != 2'd0 && item0.kind != KIND_WORD_END) begin
               nonempty_in = 1'b1;
               between_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff    <= QUOTE_NONE;
         escape_ff   <= 1'b0;
         between_ff  <= 1'b1;
         pipe_ff     <= 1'b0;
         nonempty_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         quote_ff    <= quote_in;
         escape_ff   <= escape_in;
         between_ff  <= between_in;
         pipe_ff     <= pipe_in;
         nonempty_ff <= nonempty_in;
         count_ff    <= count_in;
      end
   end

   ctlt_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_n     (push_n),
      .push_item0 (item0),
      .push_item1 (item1),
      .space_ok   (space_ok),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   assign rsp_tdata = {2'b00, out_item.has_pipeline, out_item.word_index,
                       out_item.out_byte};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last_result;

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_WORDS))
      else $error("word count beyond limit");

   a_pipe_no_escape: assert property (@(posedge clock) disable iff (reset)
      pipe_ff |-> !escape_ff)
      else $error("escape pending in pipeline mode");

   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == ACTION_EOL) |=>
         (count_ff == '0 && quote_ff == QUOTE_NONE && between_ff && !pipe_ff))
      else $error("end of line did not clear parse state");

   a_full_no_open_word: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(MAX_WORDS)) |-> !nonempty_ff)
      else $error("open word at word limit");

endmodule
